[rtl/core/ray_march_wall_column_macros.svh]
// Assertion helpers for the top module's assertions.
`ifndef RAY_MARCH_WALL_COLUMN_MACROS_SVH
`define RAY_MARCH_WALL_COLUMN_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RMWC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RMWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/rmwc_pkg.sv]
`default_nettype none
package rmwc_pkg;
  localparam int MAP_COLS = 64;
  localparam int MAP_ROWS = 16;
  localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
  localparam int CELL_AW = $clog2(MAP_CELLS);
  localparam int COL_W = 6;
  localparam int ROW_W = 4;
  localparam int TURN_W = 20;
  localparam int QDEPTH = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  localparam logic [2:0] REG_HALF_FOV = 3'd0;
  localparam logic [2:0] REG_COL_STEP = 3'd1;
  localparam logic [2:0] REG_COL_COUNT = 3'd2;
  localparam logic [2:0] REG_MAX_DEPTH = 3'd3;
  localparam logic [2:0] REG_MARCH_STEP = 3'd4;
  localparam logic [2:0] REG_PROJ_SCALE = 3'd5;

  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21165;
  localparam logic [16:0] SIN_C = 17'd2461;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [13:0] pos_y;
    logic [9:0]  column;
    logic [19:0] ray;
    logic [19:0] delta;
  } cast_job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG, ST_MARCH, ST_PROBE, ST_TEST, ST_CORR, ST_DIVH, ST_DIVS, ST_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    TR_IDLE, TR_X2, TR_T1, TR_T2, TR_T3, TR_DONE
  } trig_state_t;
endpackage
`default_nettype wire

[rtl/core/rmwc_trig.sv]
`default_nettype none
// Sequential quarter-wave sine: one multiplication per cycle, registered.
module rmwc_trig (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [19:0]         angle,
  output logic                     done,
  output logic signed [17:0]       result
);
  rmwc_pkg::trig_state_t st_r, st_nxt;
  logic [16:0] x_r, x2_r, t_r;
  logic [1:0]  quad_r;
  logic [33:0] prod;
  logic [15:0] p;
  logic [16:0] xs;
  logic [16:0] clamp;

  assign p = angle[19:4];
  assign xs = p[14] ? (17'd32768 - {2'b0, p[13:0], 1'b0}) : {2'b0, p[13:0], 1'b0};

  always_comb begin
    unique case (st_r)
      rmwc_pkg::TR_X2: prod = x_r * x_r;
      rmwc_pkg::TR_T1: prod = rmwc_pkg::SIN_C * x2_r;
      rmwc_pkg::TR_T2: prod = (rmwc_pkg::SIN_B - t_r) * x2_r;
      rmwc_pkg::TR_T3: prod = (rmwc_pkg::SIN_A - t_r) * x_r;
      default: prod = '0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    done = 1'b0;
    unique case (st_r)
      rmwc_pkg::TR_IDLE: if (start) st_nxt = rmwc_pkg::TR_X2;
      rmwc_pkg::TR_X2: st_nxt = rmwc_pkg::TR_T1;
      rmwc_pkg::TR_T1: st_nxt = rmwc_pkg::TR_T2;
      rmwc_pkg::TR_T2: st_nxt = rmwc_pkg::TR_T3;
      rmwc_pkg::TR_T3: st_nxt = rmwc_pkg::TR_DONE;
      rmwc_pkg::TR_DONE: begin
        done = 1'b1;
        st_nxt = rmwc_pkg::TR_IDLE;
      end
      default: st_nxt = rmwc_pkg::TR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= rmwc_pkg::TR_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      rmwc_pkg::TR_IDLE: begin
        x_r <= xs;
        quad_r <= p[15:14];
      end
      rmwc_pkg::TR_X2: x2_r <= prod[31:15];
      rmwc_pkg::TR_T1: t_r <= prod[31:15];
      rmwc_pkg::TR_T2: t_r <= prod[31:15];
      rmwc_pkg::TR_T3: t_r <= prod[32:16] >= 17'd1 && prod[33:15] > 19'd32768 ?
                              17'd32768 : prod[31:15];
      default: ;
    endcase
  end

  assign clamp = t_r;
  assign result = quad_r[1] ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
endmodule
`default_nettype wire

[rtl/core/rmwc_front.sv]
`default_nettype none
// Accepts items, applies map writes and queues cast jobs with their angles.
module rmwc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          in_data,
  input  wire logic [10:0]          half_fov,
  input  wire logic [15:0]          col_step,
  input  wire logic [10:0]          col_count,
  output logic                      map_we,
  output logic [rmwc_pkg::CELL_AW-1:0] map_addr,
  output logic                      map_wd,
  output logic                      job_valid,
  input  wire logic                 job_ready,
  output rmwc_pkg::cast_job_t       job
);
  rmwc_pkg::cast_job_t q_r [rmwc_pkg::QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic       acc, push, pop;
  logic [25:0] sweep;
  rmwc_pkg::cast_job_t nj;

  // A write waits until no cast is queued or marching, so every cast sees the
  // map as it stood when the cast was accepted.
  assign in_ready = (cnt_r != 2'd2) &&
                    (in_data[0] == rmwc_pkg::CMD_CAST || (cnt_r == 2'd0 && job_ready));
  assign acc = in_valid && in_ready;
  assign sweep = in_data[63:54] * col_step;
  assign push = acc && (in_data[0] == rmwc_pkg::CMD_CAST) &&
                ({1'b0, in_data[63:54]} < col_count);
  assign pop = job_valid && job_ready;
  assign job_valid = cnt_r != 2'd0;
  assign job = q_r[rd_r];
  assign map_we = acc && (in_data[0] == rmwc_pkg::CMD_WRITE);
  assign map_addr = {in_data[4:1], in_data[10:5]};
  assign map_wd = in_data[11];

  always_comb begin
    nj.pos_x = in_data[27:12];
    nj.pos_y = in_data[41:28];
    nj.column = in_data[63:54];
    nj.ray = {in_data[53:42], 8'd0} + sweep[19:0] - {1'b0, half_fov, 8'd0};
    nj.delta = {1'b0, half_fov, 8'd0} - sweep[19:0];
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    wr_nxt = push ? !wr_r : wr_r;
    rd_nxt = pop ? !rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r <= 1'b0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= nj;
  end
endmodule
`default_nettype wire

[rtl/core/rmwc_back.sv]
`default_nettype none
// Marches one ray at a time, then runs two restoring divisions.
module rmwc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_valid,
  output logic                      job_ready,
  input  wire rmwc_pkg::cast_job_t  job,
  input  wire logic [15:0]          max_depth,
  input  wire logic [9:0]           march_step,
  input  wire logic [15:0]          proj_scale,
  input  wire logic                 map_we,
  input  wire logic [rmwc_pkg::CELL_AW-1:0] map_addr,
  input  wire logic                 map_wd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [47:0]               out_data
);
  logic map_mem [rmwc_pkg::MAP_CELLS];
  logic map_rd_r;
  logic clr_busy_r;
  logic [rmwc_pkg::CELL_AW-1:0] clr_addr_r;

  rmwc_pkg::back_state_t st_r, st_nxt;
  rmwc_pkg::cast_job_t job_r;
  logic [1:0]  tsel_r;
  logic signed [17:0] cr_r, sr_r, cd_r;
  logic [16:0] d_r;
  logic [9:0]  stp;
  logic signed [35:0] px_p, py_p;
  logic signed [21:0] xq_r, yq_r;
  logic        oob_r, hit_r;
  logic [16:0] dc_r;
  logic [31:0] num_r;
  logic [16:0] rem_r;
  logic [4:0]  bit_r;
  logic [31:0] quo_r;
  logic [11:0] height_r;
  logic [7:0]  shade_r;
  logic        trig_start, trig_done;
  logic [19:0] trig_ang;
  logic signed [17:0] trig_res;
  logic signed [35:0] corr_p;
  logic [33:0] shd_p;
  logic [17:0] rem_sh;
  logic [16:0] divisor;

  rmwc_trig u_trig (
    .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(trig_ang),
    .done(trig_done), .result(trig_res)
  );

  assign stp = (march_step == 10'd0) ? 10'd1 : march_step;
  assign trig_ang = (tsel_r == 2'd1) ? job_r.ray :
                    (tsel_r == 2'd0) ? job_r.ray + 20'h40000 : job_r.delta + 20'h40000;
  assign px_p = $signed({1'b0, d_r}) * cr_r;
  assign py_p = $signed({1'b0, d_r}) * sr_r;
  assign corr_p = $signed({1'b0, d_r}) * cd_r;
  assign shd_p = dc_r * 17'd11796;
  assign divisor = (st_r == rmwc_pkg::ST_DIVH) ? dc_r : 17'd1024 + {1'b0, shd_p[31:16]};
  assign rem_sh = {rem_r, num_r[31]};
  assign job_ready = (st_r == rmwc_pkg::ST_IDLE) && !clr_busy_r;

  always_comb begin
    st_nxt = st_r;
    trig_start = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      rmwc_pkg::ST_IDLE: if (job_valid && job_ready) st_nxt = rmwc_pkg::ST_TRIG;
      rmwc_pkg::ST_TRIG: begin
        trig_start = !trig_done;
        if (trig_done && tsel_r == 2'd2) st_nxt = rmwc_pkg::ST_MARCH;
      end
      rmwc_pkg::ST_MARCH:
        st_nxt = (d_r < {1'b0, max_depth}) ? rmwc_pkg::ST_PROBE : rmwc_pkg::ST_CORR;
      rmwc_pkg::ST_PROBE: st_nxt = rmwc_pkg::ST_TEST;
      rmwc_pkg::ST_TEST:
        st_nxt = (oob_r || map_rd_r) ? rmwc_pkg::ST_CORR : rmwc_pkg::ST_MARCH;
      rmwc_pkg::ST_CORR: st_nxt = rmwc_pkg::ST_DIVH;
      rmwc_pkg::ST_DIVH: if (bit_r == 5'd0) st_nxt = rmwc_pkg::ST_DIVS;
      rmwc_pkg::ST_DIVS: if (bit_r == 5'd0) st_nxt = rmwc_pkg::ST_OUT;
      rmwc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = rmwc_pkg::ST_IDLE;
      end
      default: st_nxt = rmwc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rmwc_pkg::ST_IDLE;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) clr_busy_r <= 1'b0;
      end
    end
  end

  // Map memory: the clearing pass owns the write port after reset.
  always_ff @(posedge clk) begin
    if (clr_busy_r) map_mem[clr_addr_r] <= 1'b0;
    else if (map_we) map_mem[map_addr] <= map_wd;
    map_rd_r <= map_mem[{yq_r[13:10], xq_r[15:10]}];
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      rmwc_pkg::ST_IDLE: begin
        job_r <= job;
        tsel_r <= 2'd0;
        d_r <= {7'd0, stp};
        hit_r <= 1'b0;
      end
      rmwc_pkg::ST_TRIG: if (trig_done) begin
        if (tsel_r == 2'd0) cr_r <= trig_res;
        else if (tsel_r == 2'd1) sr_r <= trig_res;
        else cd_r <= trig_res;
        tsel_r <= tsel_r + 2'd1;
      end
      rmwc_pkg::ST_MARCH: begin
        // Arithmetic shift floors the signed product.
        xq_r <= $signed({6'd0, job_r.pos_x}) + 22'(px_p >>> 15);
        yq_r <= $signed({8'd0, job_r.pos_y}) + 22'(py_p >>> 15);
      end
      rmwc_pkg::ST_PROBE:
        oob_r <= xq_r < 0 || yq_r < 0 || xq_r[21:16] != 6'd0 || yq_r[21:14] != 8'd0;
      rmwc_pkg::ST_TEST: begin
        if (oob_r || map_rd_r) hit_r <= 1'b1;
        else d_r <= d_r + {7'd0, stp};
      end
      rmwc_pkg::ST_CORR: begin
        dc_r <= (corr_p < 0) ? 17'd0 : corr_p[31:15];
        num_r <= {6'd0, proj_scale, 10'd0};
        rem_r <= '0;
        bit_r <= 5'd31;
      end
      rmwc_pkg::ST_DIVH: begin
        if (bit_r == 5'd0) begin
          // The last height bit is taken directly; set up 255 * 1024 for the shade.
          num_r <= 32'd261120;
          rem_r <= '0;
          bit_r <= 5'd31;
        end else begin
          if (rem_sh >= {1'b0, divisor}) begin
            rem_r <= 17'(rem_sh - {1'b0, divisor});
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh[16:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
          num_r <= {num_r[30:0], 1'b0};
          bit_r <= bit_r - 5'd1;
        end
      end
      rmwc_pkg::ST_DIVS: begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem_r <= 17'(rem_sh - {1'b0, divisor});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[16:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        num_r <= {num_r[30:0], 1'b0};
        bit_r <= bit_r - 5'd1;
      end
      default: ;
    endcase
    if (st_r == rmwc_pkg::ST_DIVH && bit_r == 5'd0) begin
      if (dc_r == 17'd0) height_r <= 12'hFFF;
      else if (quo_r[30:11] != 20'd0 ||
               (rem_sh >= {1'b0, divisor} ? 1'b0 : 1'b0) || quo_r[30:0] > 31'd2047)
        height_r <= 12'hFFF;
      else height_r <= {quo_r[10:0], rem_sh >= {1'b0, divisor}};
    end
    if (st_r == rmwc_pkg::ST_DIVS && bit_r == 5'd0)
      shade_r <= (quo_r[30:7] != 24'd0) ? 8'hFF : {quo_r[6:0], rem_sh >= {1'b0, divisor}};
  end

  always_comb begin
    out_data = '0;
    out_data[9:0] = job_r.column;
    out_data[21:10] = height_r;
    out_data[28:22] = shade_r[7:1];
    out_data[36:29] = shade_r;
    out_data[43:37] = 7'(({8'd0, shade_r} * 16'd171) >> 9);
    out_data[44] = hit_r;
  end
endmodule
`default_nettype wire

[rtl/core/ray_march_wall_column.sv]
// Ray march for one screen column over a 64 by 16 wall bitmap.
// Input items arrive on in_tvalid/in_tready/in_tdata; cmd 0 writes one map
// cell and gives no result, cmd 1 casts one column's ray and gives one item
// on out_tvalid/out_tready/out_tdata. Casts with column at or above
// column_count are dropped. Registers are written on the cfg_ channel; the
// user must write them only while the block is idle, and the block itself
// does not enforce this. A cast computes the sine and cosine terms, then
// runs march steps (address, map read, test), then the height and shade
// divisions. With default settings the march loop through the map memory's
// read port takes most of a cast's time.
// Map writes complete in the cycle they are accepted, but a write is held
// off until no cast is queued or being marched, so casts see the map in
// item order.
// The front queue holds two cast jobs, so casts keep being accepted until it is
// full while the back end marches or while its result waits for out_tready.
// After reset the map is cleared one cell at a time; writes wait during that
// pass, casts are queued but not marched, configuration is taken at once.
// A stalled result is held unchanged until taken.
`default_nettype none
`include "ray_march_wall_column_macros.svh"
module ray_march_wall_column (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd, cell_row, cell_col, cell_is_wall, pos_x, pos_y, view_angle, column
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_column, slice_height, shade_red, shade_green, shade_blue, hit_wall
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [10:0] half_fov_r;
  logic [15:0] col_step_r;
  logic [10:0] col_count_r;
  logic [15:0] max_depth_r;
  logic [9:0]  march_step_r;
  logic [15:0] proj_scale_r;
  logic        map_we, map_wd, job_valid, job_ready;
  logic [rmwc_pkg::CELL_AW-1:0] map_addr;
  rmwc_pkg::cast_job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_fov_r <= 11'd341;
      col_step_r <= 16'd583;
      col_count_r <= 11'd300;
      max_depth_r <= 16'd8192;
      march_step_r <= 10'd10;
      proj_scale_r <= 16'd260;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rmwc_pkg::REG_HALF_FOV: half_fov_r <= cfg_data[10:0];
        rmwc_pkg::REG_COL_STEP: col_step_r <= cfg_data;
        rmwc_pkg::REG_COL_COUNT: col_count_r <= cfg_data[10:0];
        rmwc_pkg::REG_MAX_DEPTH: max_depth_r <= cfg_data;
        rmwc_pkg::REG_MARCH_STEP: march_step_r <= cfg_data[9:0];
        rmwc_pkg::REG_PROJ_SCALE: proj_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rmwc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data(in_tdata), .half_fov(half_fov_r), .col_step(col_step_r),
    .col_count(col_count_r), .map_we(map_we), .map_addr(map_addr), .map_wd(map_wd),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  rmwc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .max_depth(max_depth_r), .march_step(march_step_r), .proj_scale(proj_scale_r),
    .map_we(map_we), .map_addr(map_addr), .map_wd(map_wd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata)
  );

  `RMWC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RMWC_ASSERT_IMPL(a_shade_red, out_tvalid, out_tdata[28:22] == out_tdata[36:30])
  `RMWC_ASSERT_IMPL(a_job_ready, job_valid && job_ready, !out_tvalid)
endmodule
`default_nettype wire

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TURN = 64'd1 << 20;
  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct {
    logic [9:0]  column;
    logic [11:0] height;
    logic [6:0]  red;
    logic [7:0]  green;
    logic [6:0]  blue;
    logic        hit;
  } column_px_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  ray_march_wall_column i_dut (.*);

  // Shadow copy of the block's registers and wall bitmap.
  logic [10:0] half_fov_q;
  logic [15:0] col_step_q;
  logic [10:0] col_count_q;
  logic [15:0] max_depth_q;
  logic [9:0]  march_step_q;
  logic [15:0] proj_scale_q;
  logic        wall_q [rmwc_pkg::MAP_ROWS][rmwc_pkg::MAP_COLS];

  column_px_t pending_px[$];
  int         errors = 0;
  longint     cycle = 0;
  longint     hold_end = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (cycle < hold_end)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic longint quarter_sin(longint x);
    longint x2, t;
    x2 = (x * x) >>> 15;
    t = (longint'(rmwc_pkg::SIN_C) * x2) >>> 15;
    t = longint'(rmwc_pkg::SIN_B) - t;
    t = (t * x2) >>> 15;
    t = longint'(rmwc_pkg::SIN_A) - t;
    t = (t * x) >>> 15;
    if (t > 32768) t = 32768;
    if (t < 0) t = 0;
    return t;
  endfunction

  function automatic longint bam_sin(longint a);
    longint p, x, s;
    int quad;
    p = ((a % TURN) * 65536) / TURN;
    quad = int'((p >> 14) & 3);
    x = (p & 16383) << 1;
    if (quad & 1) x = 32768 - x;
    s = quarter_sin(x);
    return (quad & 2) ? -s : s;
  endfunction

  function automatic longint bam_cos(longint a);
    return bam_sin((a % TURN) + TURN / 4);
  endfunction

  function automatic longint floor_q15(longint v);
    if (v >= 0) return v >>> 15;
    return -(((-v) + 32767) >>> 15);
  endfunction

  function automatic bit cell_blocked(longint xq, longint yq);
    longint cx, cy;
    if (xq < 0 || yq < 0) return 1'b1;
    cx = xq >>> 10;
    cy = yq >>> 10;
    if (cx >= rmwc_pkg::MAP_COLS || cy >= rmwc_pkg::MAP_ROWS) return 1'b1;
    return wall_q[cy][cx];
  endfunction

  function automatic column_px_t march_column(longint px, longint py, longint view,
                                              logic [9:0] col);
    column_px_t r;
    longint sweep, half, ray, dlt, cr, sr, stp, d, dc, h, shade;
    bit hit;
    sweep = longint'(col) * longint'(col_step_q);
    half = (longint'(half_fov_q) << 8) % TURN;
    ray = (((view << 8) % TURN) + (sweep % TURN) + (TURN - half)) % TURN;
    dlt = (half + (TURN - sweep % TURN)) % TURN;
    cr = bam_cos(ray);
    sr = bam_sin(ray);
    stp = (march_step_q == 0) ? 1 : longint'(march_step_q);
    d = stp;
    hit = 1'b0;
    while (d < longint'(max_depth_q)) begin
      if (cell_blocked(px + floor_q15(d * cr), py + floor_q15(d * sr))) begin
        hit = 1'b1;
        break;
      end
      d += stp;
    end
    dc = floor_q15(d * bam_cos(dlt));
    if (dc < 0) dc = 0;
    if (dc == 0) h = 4095;
    else begin
      h = (longint'(proj_scale_q) * 1024) / dc;
      if (h > 4095) h = 4095;
    end
    shade = (255 * 1024) / (1024 + ((dc * 11796) >> 16));
    if (shade > 255) shade = 255;
    r.column = col;
    r.height = h[11:0];
    r.red = shade[7:1];
    r.green = shade[7:0];
    r.blue = 7'(shade / 3);
    r.hit = hit;
    return r;
  endfunction

  // Models the effect of one accepted item.
  task automatic absorb_item(logic [63:0] d);
    if (d[0] == rmwc_pkg::CMD_WRITE)
      wall_q[d[4:1]][d[10:5]] = d[11];
    else if (d[63:54] < col_count_q)
      pending_px.push_back(march_column(longint'(d[27:12]), longint'(d[41:28]),
                                        longint'(d[53:42]), d[63:54]));
  endtask

  task automatic send_item(logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    absorb_item(d);
  endtask

  function automatic logic [63:0] rand_bits();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_cell(int row, int col, bit wall);
    logic [63:0] d;
    d = rand_bits();
    d[0] = rmwc_pkg::CMD_WRITE;
    d[4:1] = 4'(row);
    d[10:5] = 6'(col);
    d[11] = wall;
    send_item(d);
  endtask

  task automatic send_cast(int px, int py, int view, int col);
    logic [63:0] d;
    d = rand_bits();
    d[0] = rmwc_pkg::CMD_CAST;
    d[27:12] = 16'(px);
    d[41:28] = 14'(py);
    d[53:42] = 12'(view);
    d[63:54] = 10'(col);
    send_item(d);
  endtask

  // Stops offering items and waits until every result is in and the block is quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      rmwc_pkg::REG_HALF_FOV:   half_fov_q = val[10:0];
      rmwc_pkg::REG_COL_STEP:   col_step_q = val;
      rmwc_pkg::REG_COL_COUNT:  col_count_q = val[10:0];
      rmwc_pkg::REG_MAX_DEPTH:  max_depth_q = val;
      rmwc_pkg::REG_MARCH_STEP: march_step_q = val[9:0];
      rmwc_pkg::REG_PROJ_SCALE: proj_scale_q = val;
      default: ;
    endcase
  endtask

  task automatic write_all(int hf, int cs, int cc, int md, int ms, int ps);
    write_reg(rmwc_pkg::REG_HALF_FOV, 16'(hf));
    write_reg(rmwc_pkg::REG_COL_STEP, 16'(cs));
    write_reg(rmwc_pkg::REG_COL_COUNT, 16'(cc));
    write_reg(rmwc_pkg::REG_MAX_DEPTH, 16'(md));
    write_reg(rmwc_pkg::REG_MARCH_STEP, 16'(ms));
    write_reg(rmwc_pkg::REG_PROJ_SCALE, 16'(ps));
  endtask

  always @(posedge clk) begin
    column_px_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.column = out_tdata[9:0];
      got.height = out_tdata[21:10];
      got.red = out_tdata[28:22];
      got.green = out_tdata[36:29];
      got.blue = out_tdata[43:37];
      got.hit = out_tdata[44];
      if (pending_px.size() == 0) begin
        $display("%0t unexpected result: got column %0d height %0d", $time,
                 got.column, got.height);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (got.column !== want.column) begin
          $display("%0t column: expected %0d actual %0d", $time, want.column, got.column);
          errors++;
        end
        if (got.height !== want.height) begin
          $display("%0t height: expected %0d actual %0d", $time, want.height, got.height);
          errors++;
        end
        if (got.red !== want.red) begin
          $display("%0t red: expected %0d actual %0d", $time, want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $display("%0t green: expected %0d actual %0d", $time, want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t blue: expected %0d actual %0d", $time, want.blue, got.blue);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t hit: expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
      end
    end
  end

  // Reset settings, an empty map, walls on two corners and an inner cell, then a clear.
  task automatic test_directed();
    send_cast(0, 0, 0, 0);
    send_cast(65535, 16383, 4095, 299);
    send_cast(32768, 8192, 1024, 300);
    send_cast(32768, 8192, 1024, 1023);
    send_cell(0, 0, 1'b1);
    send_cell(15, 63, 1'b1);
    send_cell(4, 10, 1'b1);
    send_cast(9 * 1024, 4 * 1024 + 512, 0, 150);
    send_cast(1500, 1500, 2560, 150);
    send_cast(62 * 1024, 14 * 1024 + 100, 512, 150);
    send_cell(4, 10, 1'b0);
    send_cast(9 * 1024, 4 * 1024 + 512, 0, 150);
    send_cast(2048, 8192, 2048, 0);
    send_cast(2048, 8192, 3072, 299);
    drain();
  endtask

  task automatic test_config_extremes();
    write_all(0, 0, 1024, 65535, 1023, 65535);
    send_cast(32 * 1024, 8 * 1024, 0, 0);
    send_cast(10 * 1024, 3 * 1024, 1000, 1023);
    send_cast(0, 16383, 3000, 512);
    drain();
    write_all(2047, 65535, 1, 1, 0, 0);
    send_cast(32 * 1024, 8 * 1024, 0, 0);
    send_cast(32 * 1024, 8 * 1024, 0, 1);
    send_cast(65535, 0, 4095, 0);
    drain();
    // A march step of zero, cast from next to a corner wall.
    write_all(341, 583, 300, 600, 0, 260);
    send_cast(1024 + 300, 1024 + 300, 1024, 10);
    drain();
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int n);
    int cc;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    cc = ($urandom_range(3) == 0) ? $urandom_range(1, 1024) : 1024;
    write_all($urandom_range(2047), $urandom(), cc, $urandom_range(1, 8192),
              $urandom_range(8, 1023), $urandom());
    for (int i = 0; i < n; i++) begin
      logic [63:0] d;
      d = rand_bits();
      if ($urandom_range(99) < 30) begin
        d[0] = rmwc_pkg::CMD_WRITE;
        d[11] = ($urandom_range(99) < 35);
      end else
        d[0] = rmwc_pkg::CMD_CAST;
      send_item(d);
    end
    drain();
  endtask

  // The receiver stalls long enough for the job queue to fill and block input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(341, 583, 1024, 2048, 16, 260);
    hold_end = cycle + 20000;
    for (int i = 0; i < 8; i++)
      send_cast($urandom_range(65535), $urandom_range(16383), $urandom_range(4095),
                $urandom_range(1023));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    half_fov_q = 11'd341;
    col_step_q = 16'd583;
    col_count_q = 11'd300;
    max_depth_q = 16'd8192;
    march_step_q = 10'd10;
    proj_scale_q = 16'd260;
    foreach (wall_q[r, c]) wall_q[r][c] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_traffic(10, 83, 180);
    test_random_traffic(83, 10, 180);
    test_random_traffic(0, 0, 190);
    test_backpressure();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
